// File: hw/rtl/cse_pkg.sv
// Shared types, codes and character constants of the context string escaper.
package cse_pkg;

  localparam int unsigned MaxBytes = 6;
  localparam int unsigned CntW     = 3;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_JSON  = 3'd1,
    MODE_SHELL = 3'd2,
    MODE_SQL   = 3'd3,
    MODE_HTML  = 3'd4
  } mode_e;

  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChLt     = 8'h3c;
  localparam logic [7:0] ChGt     = 8'h3e;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChThree  = 8'h33;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLa     = 8'h61;
  localparam logic [7:0] ChLb     = 8'h62;
  localparam logic [7:0] ChLf     = 8'h66;
  localparam logic [7:0] ChLg     = 8'h67;
  localparam logic [7:0] ChLl     = 8'h6c;
  localparam logic [7:0] ChLm     = 8'h6d;
  localparam logic [7:0] ChLn     = 8'h6e;
  localparam logic [7:0] ChLo     = 8'h6f;
  localparam logic [7:0] ChLp     = 8'h70;
  localparam logic [7:0] ChLq     = 8'h71;
  localparam logic [7:0] ChLr     = 8'h72;
  localparam logic [7:0] ChLt2    = 8'h74;
  localparam logic [7:0] ChLu     = 8'h75;

  localparam logic [7:0] CtlBs = 8'h08;
  localparam logic [7:0] CtlHt = 8'h09;
  localparam logic [7:0] CtlLf = 8'h0a;
  localparam logic [7:0] CtlFf = 8'h0c;
  localparam logic [7:0] CtlCr = 8'h0d;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       carries_byte;
    logic       start_of_string;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_done;
  } out_word_t;

  // One expanded input word: its output bytes, how many, and the end flag.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
    logic                     eos;
  } exp_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = ChZero + {4'd0, nib};
    end else begin
      d = ChLa + {4'd0, nib - 4'd10};
    end
    return d;
  endfunction

endpackage

// File: hw/rtl/cse_front.sv
// Front end: classify an input word and expand it into its escaped bytes.
module cse_front import cse_pkg::*; (
  input  logic     [2:0] mode_i,
  input  logic           push_i,
  input  logic           q_full_i,
  input  in_word_t       in_word_i,
  output logic           we_o,
  output exp_t           wdata_o
);

  logic [7:0]      body [MaxBytes];
  logic [CntW-1:0] blen;
  logic            pre;
  logic            post;
  logic            shell;
  logic [7:0]      c;

  assign c     = in_word_i.data_byte;
  assign shell = (mode_i == MODE_SHELL);
  assign pre   = shell && in_word_i.start_of_string;
  assign post  = shell && in_word_i.end_of_string;

  // Body of the escape for the byte alone, without shell framing.
  always_comb begin
    for (int i = 0; i < MaxBytes; i++) begin
      body[i] = c;
    end
    blen = CntW'(1);
    case (mode_i)
      MODE_JSON: begin
        body[0] = ChBslash;
        blen    = CntW'(2);
        case (c)
          ChDquote: body[1] = ChDquote;
          ChBslash: body[1] = ChBslash;
          ChSlash:  body[1] = ChSlash;
          CtlBs:    body[1] = ChLb;
          CtlFf:    body[1] = ChLf;
          CtlLf:    body[1] = ChLn;
          CtlCr:    body[1] = ChLr;
          CtlHt:    body[1] = ChLt2;
          default: begin
            if (c inside {[8'h00:8'h1f]}) begin
              body[1] = ChLu;
              body[2] = ChZero;
              body[3] = ChZero;
              body[4] = hex_digit(c[7:4]);
              body[5] = hex_digit(c[3:0]);
              blen    = CntW'(6);
            end else begin
              body[0] = c;
              blen    = CntW'(1);
            end
          end
        endcase
      end
      MODE_SHELL: begin
        if (c == ChSquote) begin
          body[0] = ChSquote;
          body[1] = ChBslash;
          body[2] = ChSquote;
          body[3] = ChSquote;
          blen    = CntW'(4);
        end
      end
      MODE_SQL: begin
        if (c == ChSquote || c == ChBslash) begin
          blen = CntW'(2);
        end
      end
      MODE_HTML: begin
        case (c)
          ChLt: begin
            body[0] = ChAmp; body[1] = ChLl; body[2] = ChLt2; body[3] = ChSemi;
            blen    = CntW'(4);
          end
          ChGt: begin
            body[0] = ChAmp; body[1] = ChLg; body[2] = ChLt2; body[3] = ChSemi;
            blen    = CntW'(4);
          end
          ChAmp: begin
            body[0] = ChAmp; body[1] = ChLa; body[2] = ChLm; body[3] = ChLp;
            body[4] = ChSemi;
            blen    = CntW'(5);
          end
          ChDquote: begin
            body[0] = ChAmp; body[1] = ChLq; body[2] = ChLu; body[3] = ChLo;
            body[4] = ChLt2; body[5] = ChSemi;
            blen    = CntW'(6);
          end
          ChSquote: begin
            body[0] = ChAmp; body[1] = ChHash; body[2] = ChThree; body[3] = ChNine;
            body[4] = ChSemi;
            blen    = CntW'(5);
          end
          default: blen = CntW'(1);
        endcase
      end
      default: blen = CntW'(1);
    endcase
    if (!in_word_i.carries_byte) begin
      blen = '0;
    end
  end

  // Place the opening quote, the body, then the closing quote.
  always_comb begin
    logic [CntW-1:0] j;
    for (int k = 0; k < MaxBytes; k++) begin
      j = CntW'(k) - {2'b00, pre};
      if (pre && k == 0) begin
        wdata_o.bytes[k] = ChSquote;
      end else if (j < blen) begin
        wdata_o.bytes[k] = body[j];
      end else begin
        wdata_o.bytes[k] = ChSquote;
      end
    end
    wdata_o.cnt = blen + {2'b00, pre} + {2'b00, post};
    wdata_o.eos = in_word_i.end_of_string;
  end

  // Drop words that expand to nothing.
  assign we_o = push_i && !q_full_i && (wdata_o.cnt != '0);

endmodule

// File: hw/rtl/cse_queue.sv
// Small queue of expanded words between the front and back ends.
module cse_queue import cse_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic we_i,
  input  exp_t wdata_i,
  input  logic re_i,
  output exp_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQ = $clog2(Depth + 1);

  exp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntQ-1:0] count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o  = (count_q == CntQ'(Depth));
  assign empty_o = (count_q == '0);
  assign do_wr   = we_i && !full_o;
  assign do_rd   = re_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: hw/rtl/cse_back.sv
// Back end: serialize the queued expansions into the output register.
module cse_back import cse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  exp_t      head_i,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_word_t out_word_o
);

  logic [CntW-1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  out_word_t       word_q;
  logic            load;
  logic            at_last;

  assign load    = !q_empty_i && (!valid_q || pop_i);
  assign at_last = (idx_q == head_i.cnt - 1'b1);
  assign q_pop_o = load && at_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_last ? '0 : idx_q + 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q.out_byte    <= head_i.bytes[idx_q];
      word_q.last_of_run <= at_last;
      word_q.string_done <= at_last && head_i.eos;
    end
  end

  assign empty_o    = !valid_q;
  assign out_word_o = word_q;

endmodule

// File: hw/rtl/context_string_escaper.sv
// Top level of the context string escaper: config register, front, queue, back.
//
// Usage: feed string bytes as words on the input queue port (push_i/full_o),
// one word per byte, start_of_string on the first and end_of_string on the
// last; a word with carries_byte low stands for an empty string. Escaped bytes
// come out on the result queue port (empty_o/pop_i), one byte per word, with
// last_of_run on the final byte of each input word and string_done on the
// final byte of a string-ending word. Words that expand to nothing give none.
// The escape context is set through cfg_valid_i/cfg_ready_o/cfg_data_i
// (0 plain, 1 JSON, 2 shell, 3 SQL, 4 HTML, others plain); write it only
// while the block is idle.
// An accepted word is written into the queue; its first byte then goes to the output
// register, which drives the result port. Throughput: one output byte per cycle
// from the back end serializer while the receiver pops, so a word expanding to N
// bytes (1 to 6) holds it for all N; bytes that do not expand flow one word per cycle.
// The front accepts while the queue of QUEUE_DEPTH expanded words has room.
// Reset empties the queue and the output register and sets the mode to plain.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and full_o rises once it holds QUEUE_DEPTH words.
module context_string_escaper import cse_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_data_i,
  input  logic       push_i,
  output logic       full_o,
  input  in_word_t   in_word_i,
  input  logic       pop_i,
  output logic       empty_o,
  output out_word_t  out_word_o
);

  logic [2:0] mode_q;
  logic       fe_we;
  exp_t       fe_wdata;
  exp_t       q_head;
  logic       q_full, q_empty, q_pop;

  // Mode register: always ready, take the word on a valid.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  assign full_o = q_full;

  cse_front u_front (
    .mode_i    (mode_q),
    .push_i    (push_i),
    .q_full_i  (q_full),
    .in_word_i (in_word_i),
    .we_o      (fe_we),
    .wdata_o   (fe_wdata)
  );

  cse_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (fe_we),
    .wdata_i (fe_wdata),
    .re_i    (q_pop),
    .rdata_o (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  cse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_word_o (out_word_o)
  );

`ifndef NO_ASSERTIONS
  // A word that carries a byte always expands to at least one output byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && in_word_i.carries_byte) |-> fe_we)
    else $error("byte-carrying word dropped by front end");

  // String completion only on the last byte of a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && out_word_o.string_done) |-> out_word_o.last_of_run)
    else $error("string_done without last_of_run");

  // The back end never retires a word from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");
`endif

endmodule

// File: dv/escaper_checker.sv
// Checker for the string escaper: predicts escaped bytes per input word and compares them.
module escaper_checker import cse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic [2:0] cfg_data_i,
  input  logic      push_i,
  input  logic      full_i,
  input  in_word_t  in_word_i,
  input  logic      pop_i,
  input  logic      empty_i,
  input  out_word_t out_word_i,
  output int        errors_o,
  output int        pending_o,
  output int        checked_o
);

  localparam string HexDigits = "0123456789abcdef";

  logic [2:0]  mode_q = MODE_PLAIN;
  out_word_t   expected_bytes[$];
  logic [7:0]  word_bytes[$];
  out_word_t   oldest;

  initial begin
    errors_o  = 0;
    pending_o = 0;
    checked_o = 0;
  end

  // Append one byte to the expansion of the current word.
  function automatic void add_byte(logic [7:0] b);
    word_bytes = {word_bytes, b};
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
    end
  endfunction

  // Expand one accepted input word into its escaped bytes for the current mode.
  function automatic void escape_word(logic [2:0] mode, in_word_t w);
    logic [7:0] c;
    out_word_t  o;
    c = w.data_byte;
    word_bytes.delete();
    if (mode == MODE_SHELL && w.start_of_string) begin
      add_text("'");
    end
    if (w.carries_byte) begin
      if (c >= 8'h80) begin
        add_byte(c);
      end else begin
        case (mode)
          MODE_JSON: begin
            case (c)
              ChDquote: add_text("\\\"");
              ChBslash: add_text("\\\\");
              ChSlash:  add_text("\\/");
              CtlBs:    add_text("\\b");
              CtlFf:    add_text("\\f");
              CtlLf:    add_text("\\n");
              CtlCr:    add_text("\\r");
              CtlHt:    add_text("\\t");
              default: begin
                if (c < 8'h20) begin
                  add_text("\\u00");
                  add_byte(HexDigits[c[7:4]]);
                  add_byte(HexDigits[c[3:0]]);
                end else begin
                  add_byte(c);
                end
              end
            endcase
          end
          MODE_SHELL: begin
            if (c == ChSquote) add_text("'\\''");
            else add_byte(c);
          end
          MODE_SQL: begin
            if (c == ChSquote) add_text("''");
            else if (c == ChBslash) add_text("\\\\");
            else add_byte(c);
          end
          MODE_HTML: begin
            case (c)
              ChLt:     add_text("&lt;");
              ChGt:     add_text("&gt;");
              ChAmp:    add_text("&amp;");
              ChDquote: add_text("&quot;");
              ChSquote: add_text("&#39;");
              default:  add_byte(c);
            endcase
          end
          default: add_byte(c);
        endcase
      end
    end
    if (mode == MODE_SHELL && w.end_of_string) begin
      add_text("'");
    end
    for (int k = 0; k < word_bytes.size(); k++) begin
      o.out_byte     = word_bytes[k];
      o.last_of_run  = (k == word_bytes.size() - 1);
      o.string_done  = o.last_of_run & w.end_of_string;
      expected_bytes = {expected_bytes, o};
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = MODE_PLAIN;
      expected_bytes.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        mode_q = cfg_data_i;
      end
      // Compare before adding, so a byte can never match a word accepted on this edge.
      if (pop_i && !empty_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output word: out_byte %h last_of_run %b string_done %b",
                 out_word_i.out_byte, out_word_i.last_of_run, out_word_i.string_done);
          errors_o++;
        end else begin
          oldest = expected_bytes.pop_front();
          if (out_word_i.out_byte !== oldest.out_byte) begin
            $error("out_byte: expected %h, got %h", oldest.out_byte, out_word_i.out_byte);
            errors_o++;
          end
          if (out_word_i.last_of_run !== oldest.last_of_run) begin
            $error("last_of_run: expected %b, got %b",
                   oldest.last_of_run, out_word_i.last_of_run);
            errors_o++;
          end
          if (out_word_i.string_done !== oldest.string_done) begin
            $error("string_done: expected %b, got %b",
                   oldest.string_done, out_word_i.string_done);
            errors_o++;
          end
          checked_o++;
        end
      end
      if (push_i && !full_i) begin
        escape_word(mode_q, in_word_i);
      end
    end
    pending_o = expected_bytes.size();
  end

endmodule

// File: dv/testbench.sv
// Testbench top: drives strings through the escaper in every mode and reports the verdict.
module testbench;
  import cse_pkg::*;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned RandomWords  = 195;
  localparam int unsigned LongHold     = 80;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned DrainCycles  = 16;
  // Unassigned mode code; the block decodes it as plain.
  localparam logic [2:0]  ModeSpare    = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_data = MODE_PLAIN;
  logic       push = 1'b0;
  logic       full;
  in_word_t   in_word = '0;
  logic       pop = 1'b0;
  logic       empty;
  out_word_t  out_word;

  int errors;
  int pending;
  int checked;

  int unsigned cycle_count = 0;
  int          words_sent  = 0;
  int          mode_writes = 0;
  // Sender/receiver coordination: no sender gaps, no idling at all, long hold request.
  bit          steady    = 1'b0;
  bit          calm      = 1'b0;
  bit          stall_req = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  context_string_escaper i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .push_i     (push),
    .full_o     (full),
    .in_word_i  (in_word),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_word_o (out_word)
  );

  escaper_checker i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_data_i (cfg_data),
    .push_i     (push),
    .full_i     (full),
    .in_word_i  (in_word),
    .pop_i      (pop),
    .empty_i    (empty),
    .out_word_i (out_word),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d bytes outstanding", cycle_count, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one word and hold it until accepted; then maybe idle for a burst.
  task automatic send_word(in_word_t w);
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
    if (!calm && !steady && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic offer(logic [7:0] b, logic has, logic sos, logic eos);
    in_word_t w;
    w.data_byte       = b;
    w.carries_byte    = has;
    w.start_of_string = sos;
    w.end_of_string   = eos;
    send_word(w);
  endtask

  // Drain everything, let the block settle, then write the mode.
  task automatic write_mode(logic [2:0] m);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  // Favor the bytes that expand in some mode, plus control and high bytes.
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        case ($urandom_range(0, 11))
          0:       c = ChDquote;
          1:       c = ChSquote;
          2:       c = ChBslash;
          3:       c = ChSlash;
          4:       c = ChLt;
          5:       c = ChGt;
          6:       c = ChAmp;
          7:       c = CtlBs;
          8:       c = CtlHt;
          9:       c = CtlLf;
          10:      c = CtlFf;
          default: c = CtlCr;
        endcase
      end
      5, 6:    c = 8'($urandom_range(0, 31));
      7:       c = 8'($urandom_range(128, 255));
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // Send one well-formed string; now and then break its framing or drop a byte.
  task automatic send_string(int unsigned len);
    in_word_t w;
    if (len == 0) begin
      offer(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
    end else begin
      for (int unsigned k = 0; k < len; k++) begin
        w.data_byte       = pick_char();
        w.carries_byte    = 1'b1;
        w.start_of_string = (k == 0);
        w.end_of_string   = (k == len - 1);
        if ($urandom_range(0, 14) == 0) begin
          w.carries_byte    = 1'($urandom_range(0, 1));
          w.start_of_string = 1'($urandom_range(0, 1));
          w.end_of_string   = 1'($urandom_range(0, 1));
        end
        send_word(w);
      end
    end
  endtask

  // Result side: random pop bursts, one long hold on request, steady pop when calm.
  initial begin
    @(posedge clk);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        pop <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Stimulus: directed words per mode, then random phases with mode changes.
  initial begin
    logic [2:0]  mode_plan[6];
    int          phase;
    int          phase_end;
    mode_plan = '{MODE_SHELL, MODE_JSON, MODE_HTML, MODE_SQL, MODE_PLAIN, ModeSpare};
    phase = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Plain: extreme bytes and an empty string, which gives nothing.
    write_mode(MODE_PLAIN);
    offer(8'h00, 1'b1, 1'b1, 1'b1);
    offer(8'hff, 1'b1, 1'b1, 1'b1);
    offer(8'h5a, 1'b0, 1'b1, 1'b1);

    // JSON: escaped punctuation, a named control, a hex-coded control, a high byte.
    write_mode(MODE_JSON);
    offer(ChDquote, 1'b1, 1'b1, 1'b0);
    offer(ChBslash, 1'b1, 1'b0, 1'b0);
    offer(ChSlash,  1'b1, 1'b0, 1'b0);
    offer(CtlFf,    1'b1, 1'b0, 1'b0);
    offer(8'h1f,    1'b1, 1'b0, 1'b0);
    offer(8'h80,    1'b1, 1'b0, 1'b1);

    // Shell: a lone quote yields six bytes; an empty string yields the two quotes;
    // a byteless end word just closes the string.
    write_mode(MODE_SHELL);
    offer(ChSquote, 1'b1, 1'b1, 1'b1);
    offer(8'h00,    1'b0, 1'b1, 1'b1);
    offer(8'h61,    1'b1, 1'b1, 1'b0);
    offer(8'h62,    1'b1, 1'b0, 1'b0);
    offer(8'hff,    1'b0, 1'b0, 1'b1);

    // SQL: doubled quote and backslash; end word with no output gives no string_done.
    write_mode(MODE_SQL);
    offer(ChSquote, 1'b1, 1'b1, 1'b0);
    offer(ChBslash, 1'b1, 1'b0, 1'b0);
    offer(8'h00,    1'b0, 1'b0, 1'b1);

    // HTML: all five entities.
    write_mode(MODE_HTML);
    offer(ChLt,     1'b1, 1'b1, 1'b0);
    offer(ChGt,     1'b1, 1'b0, 1'b0);
    offer(ChAmp,    1'b1, 1'b0, 1'b0);
    offer(ChDquote, 1'b1, 1'b0, 1'b0);
    offer(ChSquote, 1'b1, 1'b0, 1'b1);

    // Unassigned code behaves as plain.
    write_mode(ModeSpare);
    offer(ChSquote, 1'b1, 1'b1, 1'b1);

    // Random phases; every phase starts drained. Phase 1 holds the result side
    // off while words keep coming, so the queue fills; the last phase has no idling.
    phase_end = words_sent + RandomWords;
    while (words_sent < phase_end) begin
      if (phase < 6) write_mode(mode_plan[phase]);
      else write_mode(3'($urandom_range(0, 7)));
      if (words_sent + 40 >= phase_end) calm = 1'b1;
      if (phase == 1) begin
        steady    = 1'b1;
        stall_req = 1'b1;
        wait (!stall_req);
      end
      for (int n = words_sent + 30; words_sent < n;) begin
        send_string($urandom_range(0, 10));
      end
      steady = 1'b0;
      phase++;
    end

    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d escaped bytes produced from %0d input words.", checked, words_sent);
    $display("Mode written %0d times: plain, JSON, shell, SQL, HTML and a spare code.",
             mode_writes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
